// ===== rtl/core/sprite_line_search_unit_assert.svh =====
// Assertion macros used by the checker of the sprite line search unit.
`ifndef SPRITE_LINE_SEARCH_UNIT_ASSERT_SVH
`define SPRITE_LINE_SEARCH_UNIT_ASSERT_SVH

// Same-cycle implication, switched off while reset is applied.
`define SLSU_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sprite line search check failed");

// Next-cycle implication, switched off while reset is applied.
`define SLSU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sprite line search check failed");

// Next-cycle implication that also holds across reset.
`define SLSU_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("sprite line search check failed");

`endif

// ===== rtl/core/slsu_pkg.sv =====
`default_nettype none

package slsu_pkg;

    // Most sprites that may be found on one display line.
    localparam int MAX_PER_LINE = 10;

    localparam int COUNT_W   = 4;
    localparam int S_DATA_W  = 40;
    localparam int M_DATA_W  = 32;
    localparam int ADDR_W    = 3;

    // Register indexes, taken from paddr[2].
    localparam logic REG_SPRITES_ENABLED = 1'b0;
    localparam logic REG_TALL_SPRITES    = 1'b1;

    // Attribute flag bit positions.
    localparam int FLAG_PALETTE  = 4;
    localparam int FLAG_MIRROR_X = 5;
    localparam int FLAG_FLIP_Y   = 6;
    localparam int FLAG_BEHIND   = 7;

endpackage

`default_nettype wire

// ===== rtl/core/sprite_line_search_unit.sv =====
`default_nettype none

// Channel   | Direction | Words carried
// ----------+-----------+----------------------------------------------------
// s_        | in        | one object attribute entry plus the current line
// m_        | out       | one record for each sprite found on the line
// apb       | in/out    | register 0 sprites_enabled, register 1 tall_sprites
//
// One word is accepted in every cycle unless m_ stalls; a found record is held
// in the entry register and then the result register, with the coverage test
// and count update between them, before it is offered on m_.
// aresetn is synchronous and active low; it clears the valid flags, the found
// count and both configuration registers.
// A stall on m_ only holds the entry register once the result register is full.

module sprite_line_search_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // Entry channel.
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // tdata, lowest bit up: scan_line[7:0], sprite_y[15:8], sprite_x[23:16],
    // tile_number[31:24], attr_flags[39:32].
    input  wire logic [slsu_pkg::S_DATA_W-1:0] s_tdata,
    // tuser: first_of_line.
    input  wire logic                          s_tuser,
    // Record channel.
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // tdata, lowest bit up: screen_x[8:0], tile_index[16:9], tile_row[19:17],
    // palette_select[20], behind_background[21], mirror_x[22], slot[26:23],
    // zero padding[31:27].
    output logic [slsu_pkg::M_DATA_W-1:0]      m_tdata,
    // Configuration port.
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [slsu_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    // Configuration registers.
    logic enable_reg;
    logic tall_reg;

    // Entry register.
    logic                          in_valid_reg;
    logic [slsu_pkg::S_DATA_W-1:0] in_data_reg;
    logic                          in_first_reg;

    // Result register.
    logic                          out_valid_reg;
    logic [slsu_pkg::M_DATA_W-1:0] out_data_reg;

    logic [slsu_pkg::COUNT_W-1:0]  count_reg;
    logic [slsu_pkg::COUNT_W-1:0]  count_next;

    logic       advance;
    logic       cfg_write;
    logic [7:0] line;
    logic [7:0] ypos;
    logic [7:0] xpos;
    logic [7:0] tile;
    logic [7:0] flags;
    logic [8:0] line_end;
    logic [8:0] row_full;
    logic [3:0] row;
    logic       covered;
    logic       row_ok;
    logic       flip_y;
    logic       line_full;
    logic       hit;
    logic [slsu_pkg::COUNT_W-1:0] count_base;
    logic [8:0] screen_x;
    logic [7:0] tile_index;
    logic [2:0] tile_row;
    logic [slsu_pkg::M_DATA_W-1:0] out_data_next;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb begin
        prdata = '0;
        case (paddr[2])
            slsu_pkg::REG_SPRITES_ENABLED: prdata[0] = enable_reg;
            slsu_pkg::REG_TALL_SPRITES:    prdata[0] = tall_reg;
            default:                       prdata    = '0;
        endcase
    end

    // The entry register moves on whenever the result register is free or
    // being emptied; an entry that finds nothing simply leaves it empty.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign line  = in_data_reg[7:0];
    assign ypos  = in_data_reg[15:8];
    assign xpos  = in_data_reg[23:16];
    assign tile  = in_data_reg[31:24];
    assign flags = in_data_reg[39:32];

    // Row within the sprite is line + 16 - y; the entry covers the line when
    // y lies below the line and no more than 16 rows below it.
    assign line_end = {1'b0, line} + 9'd16;
    assign row_full = line_end - {1'b0, ypos};
    assign row      = row_full[3:0];
    assign covered  = ({1'b0, ypos} > {1'b0, line}) && ({1'b0, ypos} <= line_end);
    assign row_ok   = tall_reg || !row[3];
    assign flip_y   = flags[slsu_pkg::FLAG_FLIP_Y];

    // A first-of-line entry starts from an empty count.
    assign count_base = in_first_reg ? '0 : count_reg;
    assign line_full  = count_base >= slsu_pkg::COUNT_W'(slsu_pkg::MAX_PER_LINE);
    assign hit        = enable_reg && !line_full && covered && row_ok;
    assign count_next = hit ? count_base + 1'b1 : count_base;

    // In tall mode the lower tile of the pair holds rows 0 to 7; flipping
    // swaps the pair as well as the rows inside each tile.
    assign screen_x   = {1'b0, xpos} - 9'd8;
    assign tile_index = tall_reg ? {tile[7:1], row[3] ^ flip_y} : tile;
    assign tile_row   = row[2:0] ^ {3{flip_y}};

    assign out_data_next = {5'b0, count_base, flags[slsu_pkg::FLAG_MIRROR_X],
                            flags[slsu_pkg::FLAG_BEHIND], flags[slsu_pkg::FLAG_PALETTE],
                            tile_row, tile_index, screen_x};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg    <= 1'b0;
            tall_reg      <= 1'b0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end else begin
            if (cfg_write) begin
                case (paddr[2])
                    slsu_pkg::REG_SPRITES_ENABLED: enable_reg <= pwdata[0];
                    slsu_pkg::REG_TALL_SPRITES:    tall_reg   <= pwdata[0];
                    default:                       enable_reg <= enable_reg;
                endcase
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= hit;
                count_reg     <= count_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg  <= s_tdata;
            in_first_reg <= s_tuser;
        end
        if (advance && hit) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/slsu_checker.sv =====
`default_nettype none

`include "sprite_line_search_unit_assert.svh"

module slsu_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [slsu_pkg::M_DATA_W-1:0] m_tdata
);

    // Reset leaves no record waiting.
    `SLSU_ASSERT_NEXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_tvalid)

    // A stalled record holds its word.
    `SLSU_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // With the record side draining, entries are never held back.
    `SLSU_ASSERT_NOW(a_no_backpressure, aclk, aresetn, m_tready, s_tready)

    // The slot never reaches the line limit, and the padding stays clear.
    `SLSU_ASSERT_NOW(a_slot_range, aclk, aresetn, m_tvalid, (m_tdata[26:23] < slsu_pkg::COUNT_W'(slsu_pkg::MAX_PER_LINE)) && (m_tdata[31:27] == 5'b0))

endmodule

bind sprite_line_search_unit slsu_checker u_slsu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
